/* sv/bpa_pkg.sv */
// Shared constants and codes for the buddy page allocator.
// No dependencies; compiled first.
package bpa_pkg;

  localparam int TOP_ORDER  = 10;
  localparam int NUM_PAGES  = 1024;
  localparam int NUM_ORDERS = TOP_ORDER + 1;
  localparam int PAGE_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int HEAD_W     = 11;
  localparam int ORD_W      = 4;
  localparam int STAT_W     = 2;

  localparam logic [HEAD_W-1:0] LIST_EMPTY = HEAD_W'(NUM_PAGES);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_DBLFREE = 2'd2;

endpackage

/* sv/bpa_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on bpa_pkg.
interface bpa_req_if;
  import bpa_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [COUNT_W-1:0] page_count;
  logic [PAGE_W-1:0]  first_page;

  modport source (output valid, action, page_count, first_page, input ready);
  modport sink   (input valid, action, page_count, first_page, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PAGE_W-1:0] block_page;

  modport source (output valid, status, block_page, input ready);
  modport sink   (input valid, status, block_page, output ready);
endinterface

/* sv/bpa_ram.sv */
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/buddy_page_allocator.sv */
// Buddy page allocator: request channel in, one response word per request out.
// Free lists live in three RAMs: next link, prev link, and {free, order} per page.
// Channels: req_i carries action (0 alloc, 1 free), page_count and first_page;
// rsp_o returns status (0 done, 1 no space / refused, 2 double free) and
// block_page (first page of an allocated block, zero otherwise).
// One request is worked at a time. The page count is rounded up to a power of
// two. An allocation walks down from the lowest non-empty order, each split
// made of one unlink, an insert into an empty list and an insert after a
// head; then the block is unlinked and the result handed off. A free checks
// the page's free flag and inserts the block, then per merge level unlinks
// both buddies and inserts the merged block. The registered link RAM reads
// and the single write port per RAM set the per-step cost.
// After reset a clearing pass writes every RAM entry, leaving one free block
// of order 10 at page 0; req_i.ready stays low during it.
// The result sits in an output register; a new request is accepted while it
// waits, but the next result is held until rsp_o is taken.
module buddy_page_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  import bpa_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ALLOC  = 4'd2;
  localparam logic [3:0] S_SPLIT1 = 4'd3;
  localparam logic [3:0] S_SPLIT2 = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_MRG_A  = 4'd6;
  localparam logic [3:0] S_MRG_B  = 4'd7;
  localparam logic [3:0] S_MRG_C  = 4'd8;
  localparam logic [3:0] S_MRG_D  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;
  localparam logic [3:0] S_INS_A  = 4'd11;
  localparam logic [3:0] S_INS_B  = 4'd12;
  localparam logic [3:0] S_INS_C  = 4'd13;
  localparam logic [3:0] S_REM_A  = 4'd14;
  localparam logic [3:0] S_REM_B  = 4'd15;

  typedef struct packed {
    logic             free;
    logic [ORD_W-1:0] order;
  } meta_t;

  function automatic logic [ORD_W-1:0] round_order(input logic [COUNT_W-1:0] n);
    logic [ORD_W-1:0] o;
    o = '0;
    for (int i = 0; i <= COUNT_W; i++) begin
      if ({1'b0, n} > (COUNT_W+1)'(1) << i) begin
        o = ORD_W'(i + 1);
      end
    end
    return o;
  endfunction

  logic [3:0]        state_q, state_d, ret_q, ret_d;
  logic [PAGE_W-1:0] op_p_q, op_p_d, p_q, p_d, b_q, b_d, clr_q;
  logic [ORD_W-1:0]  op_o_q, op_o_d, c_q, c_d, ord_q, ord_d;
  logic [HEAD_W-1:0] head_q [NUM_ORDERS];
  logic [HEAD_W-1:0] head_d [NUM_ORDERS];
  logic [STAT_W-1:0] res_status_q, res_status_d, out_status_q;
  logic [PAGE_W-1:0] res_page_q, res_page_d, out_page_q;
  logic              out_valid_q, out_valid_d, out_load;

  logic              nx_we, pv_we, mt_we;
  logic [PAGE_W-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [PAGE_W-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;
  logic [PAGE_W-1:0] mt_waddr, mt_raddr;
  meta_t             mt_wdata, mt_rdata;

  logic [ORD_W-1:0]  req_ord, find_c;
  logic              find_ok;
  logic [HEAD_W-1:0] op_head;
  logic [PAGE_W-1:0] low_p;

  bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );
  bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );
  bpa_ram #(.WIDTH(ORD_W+1), .DEPTH(NUM_PAGES)) u_meta (
    .clk_i, .we_i(mt_we), .waddr_i(mt_waddr), .wdata_i(mt_wdata),
    .raddr_i(mt_raddr), .rdata_o(mt_rdata)
  );

  assign req_ord = round_order(req_i.page_count);
  assign op_head = head_q[op_o_q];
  assign low_p   = (b_q < p_q) ? b_q : p_q;

  // lowest non-empty order at or above the request
  always_comb begin
    find_c  = '0;
    find_ok = 1'b0;
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (ORD_W'(i) >= req_ord && head_q[i] != LIST_EMPTY) begin
        find_c  = ORD_W'(i);
        find_ok = 1'b1;
      end
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    op_p_d       = op_p_q;
    op_o_d       = op_o_q;
    p_d          = p_q;
    b_d          = b_q;
    c_d          = c_q;
    ord_d        = ord_q;
    head_d       = head_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
    pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_raddr = '0;
    mt_we = 1'b0; mt_waddr = '0; mt_wdata = '0; mt_raddr = '0;

    unique case (state_q)
      S_CLR: begin
        nx_we = 1'b1; nx_waddr = clr_q;
        pv_we = 1'b1; pv_waddr = clr_q;
        mt_we = 1'b1; mt_waddr = clr_q;
        if (clr_q == '0) begin
          mt_wdata = '{free: 1'b1, order: ORD_W'(TOP_ORDER)};
        end
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          ord_d        = req_ord;
          res_status_d = ST_OK;
          res_page_d   = '0;
          p_d          = req_i.first_page;
          if (req_ord > ORD_W'(TOP_ORDER)) begin
            res_status_d = ST_NOSPACE;
            state_d      = S_DONE;
          end else if (req_i.action == ACT_ALLOC) begin
            if (!find_ok) begin
              res_status_d = ST_NOSPACE;
              state_d      = S_DONE;
            end else begin
              c_d     = find_c;
              state_d = S_ALLOC;
            end
          end else begin
            mt_raddr = req_i.first_page;
            state_d  = S_FCHK;
          end
        end
      end
      S_ALLOC: begin
        if (c_q > ord_q) begin
          p_d     = head_q[c_q][PAGE_W-1:0];
          op_p_d  = head_q[c_q][PAGE_W-1:0];
          op_o_d  = c_q;
          ret_d   = S_SPLIT1;
          state_d = S_REM_A;
        end else begin
          res_page_d = head_q[ord_q][PAGE_W-1:0];
          op_p_d     = head_q[ord_q][PAGE_W-1:0];
          op_o_d     = ord_q;
          ret_d      = S_DONE;
          state_d    = S_REM_A;
        end
      end
      S_SPLIT1: begin
        op_p_d  = p_q;
        op_o_d  = c_q - 1'b1;
        ret_d   = S_SPLIT2;
        state_d = S_INS_A;
      end
      S_SPLIT2: begin
        // buddy of the kept lower half
        op_p_d  = p_q ^ (PAGE_W'(1) << (c_q - 1'b1));
        op_o_d  = c_q - 1'b1;
        c_d     = c_q - 1'b1;
        ret_d   = S_ALLOC;
        state_d = S_INS_A;
      end
      S_FCHK: begin
        if (mt_rdata.free) begin
          res_status_d = ST_DBLFREE;
          state_d      = S_DONE;
        end else begin
          op_p_d  = p_q;
          op_o_d  = ord_q;
          ret_d   = S_MRG_A;
          state_d = S_INS_A;
        end
      end
      S_MRG_A: begin
        if (ord_q < ORD_W'(TOP_ORDER)) begin
          b_d      = p_q ^ (PAGE_W'(1) << ord_q);
          mt_raddr = p_q ^ (PAGE_W'(1) << ord_q);
          state_d  = S_MRG_B;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MRG_B: begin
        if (mt_rdata.free && mt_rdata.order == ord_q) begin
          op_p_d  = b_q;
          op_o_d  = ord_q;
          ret_d   = S_MRG_C;
          state_d = S_REM_A;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MRG_C: begin
        op_p_d  = p_q;
        op_o_d  = ord_q;
        ret_d   = S_MRG_D;
        state_d = S_REM_A;
      end
      S_MRG_D: begin
        p_d     = low_p;
        op_p_d  = low_p;
        op_o_d  = ord_q + 1'b1;
        ord_d   = ord_q + 1'b1;
        ret_d   = S_MRG_A;
        state_d = S_INS_A;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_INS_A: begin
        if (op_head == LIST_EMPTY) begin
          head_d[op_o_q] = {1'b0, op_p_q};
          nx_we = 1'b1; nx_waddr = op_p_q; nx_wdata = op_p_q;
          pv_we = 1'b1; pv_waddr = op_p_q; pv_wdata = op_p_q;
          mt_we = 1'b1; mt_waddr = op_p_q;
          mt_wdata = '{free: 1'b1, order: op_o_q};
          state_d  = ret_q;
        end else begin
          nx_raddr = op_head[PAGE_W-1:0];
          state_d  = S_INS_B;
        end
      end
      S_INS_B: begin
        // nx_rdata is the entry after the head
        nx_we = 1'b1; nx_waddr = op_p_q;   nx_wdata = nx_rdata;
        pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = op_p_q;
        mt_we = 1'b1; mt_waddr = op_p_q;
        mt_wdata = '{free: 1'b1, order: op_o_q};
        state_d  = S_INS_C;
      end
      S_INS_C: begin
        nx_we = 1'b1; nx_waddr = op_head[PAGE_W-1:0]; nx_wdata = op_p_q;
        pv_we = 1'b1; pv_waddr = op_p_q; pv_wdata = op_head[PAGE_W-1:0];
        state_d = ret_q;
      end
      S_REM_A: begin
        nx_raddr = op_p_q;
        pv_raddr = op_p_q;
        state_d  = S_REM_B;
      end
      S_REM_B: begin
        if (nx_rdata == op_p_q) begin
          head_d[op_o_q] = LIST_EMPTY;
        end else begin
          nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
          pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
          if (op_head == {1'b0, op_p_q}) begin
            head_d[op_o_q] = {1'b0, nx_rdata};
          end
        end
        mt_we = 1'b1; mt_waddr = op_p_q;
        mt_wdata = '{free: 1'b0, order: op_o_q};
        state_d  = ret_q;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_q[i] <= (i == TOP_ORDER) ? '0 : LIST_EMPTY;
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_p_q       <= op_p_d;
    op_o_q       <= op_o_d;
    p_q          <= p_d;
    b_q          <= b_d;
    c_q          <= c_d;
    ord_q        <= ord_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_page_q   <= res_page_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.block_page = out_page_q;

endmodule

/* sv/bpa_checker.sv */
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator.
module bpa_port_checks (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [bpa_pkg::STAT_W-1:0] rsp_status_i,
  input logic [bpa_pkg::PAGE_W-1:0] rsp_page_i
);
  import bpa_pkg::*;

  // one request in flight: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == ST_OK || rsp_status_i == ST_NOSPACE ||
                     rsp_status_i == ST_DBLFREE))
    else $error("undefined status code");

  a_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_page_i == '0)
    else $error("nonzero page on failed request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_page_i))
    else $error("stalled response word changed");

endmodule

bind buddy_page_allocator bpa_port_checks u_bpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_page_i   (rsp_o.block_page)
);
